FILE: src/prrts_pkg.sv
`default_nettype none
package prrts_pkg;
    localparam int TASK_SLOTS_DEF = 16;
    localparam int PRIORITY_LEVELS_DEF = 8;
    localparam int OP_W = 3;
    localparam int ID_W = 4;
    localparam int PR_W = 3;
    localparam int TICK_W = 16;
    localparam int WOKEN_W = 5;

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_READY = 3'd1;
    localparam logic [OP_W-1:0] OP_WAIT = 3'd2;
    localparam logic [OP_W-1:0] OP_SLEEP = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK = 3'd4;
    localparam logic [OP_W-1:0] OP_DISPATCH = 3'd5;

    localparam logic [1:0] ST_WAIT = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_RUN = 2'd2;

    typedef struct packed {
        logic load;
        logic do_op;
        logic disp_start;
        logic disp_step;
        logic disp_finish;
        logic tick_step;
        logic sleep_step;
    } cmd_t;

    typedef struct packed {
        logic need_disp;
        logic is_tick;
        logic is_sleep;
        logic disp_done;
        logic scan_last;
    } sts_t;
endpackage
`default_nettype wire

FILE: src/priority_round_robin_task_scheduler_unit.sv
`default_nettype none
// channel  direction  ports
// s_       in         s_valid s_ready s_operation s_task_id s_priority_req s_start_ready
//                     s_sleep_ticks
// m_       out        m_valid m_ready m_current_task m_accepted m_switched m_woken_count
// one request at a time: add and make ready are done in the op state, tick scans
// all TASK_SLOTS sleep slots, dispatch walks the levels and the ring of each level,
// sleep scans the slots and claims a free one before it dispatches
// synchronous active-low reset restores task 0 as idle task
// a result waits in its register until taken; no request accepted meanwhile
module priority_round_robin_task_scheduler_unit #(
    parameter int TASK_SLOTS = prrts_pkg::TASK_SLOTS_DEF,
    parameter int PRIORITY_LEVELS = prrts_pkg::PRIORITY_LEVELS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire  [prrts_pkg::OP_W-1:0]       s_operation,
    input  wire  [prrts_pkg::ID_W-1:0]       s_task_id,
    input  wire  [prrts_pkg::PR_W-1:0]       s_priority_req,
    input  wire                              s_start_ready,
    input  wire  [prrts_pkg::TICK_W-1:0]     s_sleep_ticks,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic [prrts_pkg::ID_W-1:0]       m_current_task,
    output logic                             m_accepted,
    output logic                             m_switched,
    output logic [prrts_pkg::WOKEN_W-1:0]    m_woken_count
);
    import prrts_pkg::*;

    cmd_t cmd;
    sts_t sts;

    prrts_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .m_valid(m_valid), .m_ready(m_ready), .cmd(cmd), .sts(sts)
    );

    prrts_dp #(.TASK_SLOTS(TASK_SLOTS), .PRIORITY_LEVELS(PRIORITY_LEVELS)) u_dp (
        .aclk(aclk), .aresetn(aresetn),
        .s_operation(s_operation), .s_task_id(s_task_id),
        .s_priority_req(s_priority_req), .s_start_ready(s_start_ready),
        .s_sleep_ticks(s_sleep_ticks),
        .m_current_task(m_current_task), .m_accepted(m_accepted),
        .m_switched(m_switched), .m_woken_count(m_woken_count),
        .cmd(cmd), .sts(sts)
    );
endmodule
`default_nettype wire

FILE: src/prrts_ctrl.sv
`default_nettype none
module prrts_ctrl (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  wire               m_ready,
    output prrts_pkg::cmd_t   cmd,
    input  prrts_pkg::sts_t   sts
);
    import prrts_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_OP    = 7'b0000010,
        S_TICK  = 7'b0000100,
        S_SLEEP = 7'b0001000,
        S_DINIT = 7'b0010000,
        S_DSCAN = 7'b0100000,
        S_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    state_next = S_OP;
                end
            end
            S_OP: begin
                if (sts.is_tick) begin
                    state_next = S_TICK;
                end else if (sts.is_sleep) begin
                    state_next = S_SLEEP;
                end else begin
                    cmd.do_op = 1'b1;
                    state_next = sts.need_disp ? S_DINIT : S_OUT;
                end
            end
            S_TICK: begin
                cmd.tick_step = 1'b1;
                if (sts.scan_last) state_next = S_OUT;
            end
            S_SLEEP: begin
                cmd.sleep_step = 1'b1;
                if (sts.scan_last) state_next = S_DINIT;
            end
            S_DINIT: begin
                cmd.disp_start = 1'b1;
                state_next = S_DSCAN;
            end
            S_DSCAN: begin
                if (sts.disp_done) begin
                    cmd.disp_finish = 1'b1;
                    state_next = S_OUT;
                end else begin
                    cmd.disp_step = 1'b1;
                end
            end
            S_OUT: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_both: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("accept while result pending");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid) else $error("result dropped");
    a_load_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !s_ready) else $error("load did not leave idle");
`endif
endmodule
`default_nettype wire

FILE: src/prrts_dp.sv
`default_nettype none
module prrts_dp #(
    parameter int TASK_SLOTS = prrts_pkg::TASK_SLOTS_DEF,
    parameter int PRIORITY_LEVELS = prrts_pkg::PRIORITY_LEVELS_DEF
) (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire  [prrts_pkg::OP_W-1:0]       s_operation,
    input  wire  [prrts_pkg::ID_W-1:0]       s_task_id,
    input  wire  [prrts_pkg::PR_W-1:0]       s_priority_req,
    input  wire                              s_start_ready,
    input  wire  [prrts_pkg::TICK_W-1:0]     s_sleep_ticks,
    output logic [prrts_pkg::ID_W-1:0]       m_current_task,
    output logic                             m_accepted,
    output logic                             m_switched,
    output logic [prrts_pkg::WOKEN_W-1:0]    m_woken_count,
    input  prrts_pkg::cmd_t                  cmd,
    output prrts_pkg::sts_t                  sts
);
    import prrts_pkg::*;

    localparam int TW = $clog2(TASK_SLOTS);
    localparam int LW = $clog2(PRIORITY_LEVELS);
    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam int SW = $clog2(TASK_SLOTS + 1);
    localparam logic [LW-1:0] LOWEST = LW'(PRIORITY_LEVELS - 1);
    localparam logic [CW-1:0] CMAX = CW'(TASK_SLOTS);

    logic [OP_W-1:0] op_reg;
    logic [ID_W-1:0] id_reg;
    logic [PR_W-1:0] pr_reg;
    logic rdy_reg;
    logic [TICK_W-1:0] ticks_reg;

    logic [TASK_SLOTS-1:0] reg_reg;
    logic [1:0] status_reg [TASK_SLOTS];
    logic [LW-1:0] level_reg [TASK_SLOTS];
    logic [TW-1:0] succ_reg [TASK_SLOTS];
    logic [TW-1:0] head_reg [PRIORITY_LEVELS];
    logic [PRIORITY_LEVELS-1:0] filled_reg;
    logic [CW-1:0] tally_reg [PRIORITY_LEVELS];
    logic [TW-1:0] run_reg;
    logic [TASK_SLOTS-1:0] sused_reg;
    logic [TW-1:0] sowner_reg [TASK_SLOTS];
    logic [TICK_W-1:0] srem_reg [TASK_SLOTS];

    logic acc_reg, sw_reg;
    logic [WOKEN_W-1:0] woken_reg;
    logic [TW-1:0] idx_reg;
    logic sfound_reg;
    logic [LW-1:0] dlvl_reg;
    logic [TW-1:0] dtask_reg;
    logic [SW-1:0] dsteps_reg;
    logic dhit_reg, dend_reg;

    logic id_ok, pr_ok, id_reg_ok, is_cur;
    logic [TW-1:0] tid;
    logic [LW-1:0] lpr;
    assign id_ok = (32'(id_reg) < TASK_SLOTS);
    assign pr_ok = (32'(pr_reg) < PRIORITY_LEVELS);
    assign tid = TW'(id_reg);
    assign lpr = LW'(pr_reg);
    assign id_reg_ok = id_ok && reg_reg[tid];
    assign is_cur = id_ok && (tid == run_reg);

    logic lvl_live;
    assign lvl_live = (tally_reg[dlvl_reg] != '0) && filled_reg[dlvl_reg];

    assign sts.is_tick = (op_reg == OP_TICK);
    assign sts.is_sleep = (op_reg == OP_SLEEP);
    assign sts.need_disp = (op_reg == OP_DISPATCH) ||
                           ((op_reg == OP_WAIT) && id_reg_ok && is_cur);
    assign sts.disp_done = dhit_reg || dend_reg;
    assign sts.scan_last = (32'(idx_reg) == TASK_SLOTS - 1);

    function automatic logic [CW-1:0] up(input logic [CW-1:0] c);
        return (c < CMAX) ? c + 1'b1 : c;
    endfunction
    function automatic logic [CW-1:0] dn(input logic [CW-1:0] c);
        return (c != '0) ? c - 1'b1 : c;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reg_reg <= TASK_SLOTS'(1);
            filled_reg <= {1'b1, {(PRIORITY_LEVELS-1){1'b0}}};
            sused_reg <= '0;
            run_reg <= '0;
            for (int i = 0; i < TASK_SLOTS; i++) begin
                status_reg[i] <= (i == 0) ? ST_RUN : ST_WAIT;
                level_reg[i] <= (i == 0) ? LOWEST : '0;
                succ_reg[i] <= '0;
                sowner_reg[i] <= '0;
                srem_reg[i] <= '0;
            end
            for (int l = 0; l < PRIORITY_LEVELS; l++) begin
                head_reg[l] <= '0;
                tally_reg[l] <= (l == PRIORITY_LEVELS - 1) ? CW'(1) : '0;
            end
        end else begin
            if (cmd.load) begin
                op_reg <= s_operation;
                id_reg <= s_task_id;
                pr_reg <= s_priority_req;
                rdy_reg <= s_start_ready;
                ticks_reg <= s_sleep_ticks;
                acc_reg <= 1'b0;
                sw_reg <= 1'b0;
                woken_reg <= '0;
                idx_reg <= '0;
                sfound_reg <= 1'b0;
            end
            if (cmd.do_op) begin
                case (op_reg)
                    OP_ADD: begin
                        if (id_ok && pr_ok && !reg_reg[tid]) begin
                            if (!filled_reg[lpr]) begin
                                head_reg[lpr] <= tid;
                                filled_reg[lpr] <= 1'b1;
                                succ_reg[tid] <= tid;
                            end else begin
                                succ_reg[tid] <= succ_reg[head_reg[lpr]];
                                succ_reg[head_reg[lpr]] <= tid;
                            end
                            level_reg[tid] <= lpr;
                            status_reg[tid] <= rdy_reg ? ST_READY : ST_WAIT;
                            if (rdy_reg) tally_reg[lpr] <= up(tally_reg[lpr]);
                            reg_reg[tid] <= 1'b1;
                            acc_reg <= 1'b1;
                        end
                    end
                    OP_READY: begin
                        if (id_reg_ok && status_reg[tid] == ST_WAIT) begin
                            status_reg[tid] <= ST_READY;
                            tally_reg[level_reg[tid]] <= up(tally_reg[level_reg[tid]]);
                            acc_reg <= 1'b1;
                        end
                    end
                    OP_WAIT: begin
                        if (id_reg_ok && (status_reg[tid] == ST_READY ||
                                          status_reg[tid] == ST_RUN)) begin
                            status_reg[tid] <= ST_WAIT;
                            tally_reg[level_reg[tid]] <= dn(tally_reg[level_reg[tid]]);
                            acc_reg <= 1'b1;
                        end
                    end
                    OP_DISPATCH: acc_reg <= 1'b1;
                    default: ;
                endcase
            end
            if (cmd.tick_step) begin
                idx_reg <= idx_reg + 1'b1;
                acc_reg <= 1'b1;
                if (sused_reg[idx_reg]) begin
                    srem_reg[idx_reg] <= srem_reg[idx_reg] - 1'b1;
                    if (srem_reg[idx_reg] == TICK_W'(1)) begin
                        sused_reg[idx_reg] <= 1'b0;
                        if (status_reg[sowner_reg[idx_reg]] == ST_WAIT) begin
                            status_reg[sowner_reg[idx_reg]] <= ST_READY;
                            tally_reg[level_reg[sowner_reg[idx_reg]]] <=
                                up(tally_reg[level_reg[sowner_reg[idx_reg]]]);
                            if (woken_reg != '1) woken_reg <= woken_reg + 1'b1;
                        end
                    end
                end
            end
            if (cmd.sleep_step) begin
                idx_reg <= idx_reg + 1'b1;
                if (!sfound_reg && !sused_reg[idx_reg]) begin
                    sfound_reg <= 1'b1;
                    acc_reg <= 1'b1;
                    sused_reg[idx_reg] <= 1'b1;
                    sowner_reg[idx_reg] <= run_reg;
                    srem_reg[idx_reg] <= ticks_reg;
                    if (status_reg[run_reg] == ST_RUN) begin
                        status_reg[run_reg] <= ST_WAIT;
                        tally_reg[level_reg[run_reg]] <= dn(tally_reg[level_reg[run_reg]]);
                    end
                end
            end
            if (cmd.disp_start) begin
                sw_reg <= 1'b1;
                if (status_reg[run_reg] == ST_RUN) status_reg[run_reg] <= ST_READY;
                dlvl_reg <= '0;
                dtask_reg <= head_reg[0];
                dsteps_reg <= '0;
                dhit_reg <= 1'b0;
                dend_reg <= 1'b0;
            end
            if (cmd.disp_step) begin
                if (lvl_live && 32'(dsteps_reg) < TASK_SLOTS &&
                    status_reg[dtask_reg] == ST_READY) begin
                    dhit_reg <= 1'b1;
                end else if (lvl_live && 32'(dsteps_reg) < TASK_SLOTS - 1) begin
                    dtask_reg <= succ_reg[dtask_reg];
                    dsteps_reg <= dsteps_reg + 1'b1;
                end else if (dlvl_reg == LOWEST) begin
                    dend_reg <= 1'b1;
                end else begin
                    dlvl_reg <= dlvl_reg + 1'b1;
                    dtask_reg <= head_reg[dlvl_reg + 1'b1];
                    dsteps_reg <= '0;
                end
            end
            if (cmd.disp_finish) begin
                if (dhit_reg) begin
                    run_reg <= dtask_reg;
                    head_reg[dlvl_reg] <= succ_reg[dtask_reg];
                    status_reg[dtask_reg] <= ST_RUN;
                end else begin
                    if (status_reg[run_reg] == ST_WAIT)
                        tally_reg[level_reg[run_reg]] <= up(tally_reg[level_reg[run_reg]]);
                    status_reg[run_reg] <= ST_RUN;
                end
            end
        end
    end

    assign m_current_task = ID_W'(run_reg);
    assign m_accepted = acc_reg;
    assign m_switched = sw_reg;
    assign m_woken_count = woken_reg;

`ifndef ASSERT_OFF
    a_hit_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.disp_finish && dhit_reg |-> status_reg[dtask_reg] == ST_READY)
        else $error("dispatch picked a task that is not ready");
    a_run_reg: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.disp_finish |=> reg_reg[run_reg]) else $error("running task unregistered");
    a_sw: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.disp_start |=> sw_reg) else $error("switch flag lost");
`endif
endmodule
`default_nettype wire
